FILE: hdl/cft_pkg.sv
package cft_pkg;

    // Build-time sizes of the phase accumulator, the sine table and the fan.
    localparam int MAX_SEGMENTS    = 63;
    localparam int MIN_SEGMENTS    = 3;
    localparam int PHASE_BITS      = 16;
    localparam int SINE_INDEX_BITS = 10;

    // Field widths fixed by the vertex and index formats.
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int TRIG_W      = 15;
    localparam int BASE_W      = 20;
    localparam int INDEX_W     = 21;
    localparam int SEGS_CFG_W  = 6;
    localparam int STEP_W      = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;

    // Derived sizes.
    localparam int SEG_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int SINE_N     = 1 << SINE_INDEX_BITS;
    localparam int ROM_ADDR_W = SINE_INDEX_BITS + 1;
    localparam int TOP_W      = SINE_INDEX_BITS + 2;
    localparam int PROD_W     = RADIUS_W + TRIG_W;
    localparam int FRAC_BITS  = 14;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int SUM_W      = COORD_W + 2;

    // Saturation limits of a vertex coordinate.
    localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(1 << (COORD_W - 1));

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [SEGS_CFG_W-1:0] SEGMENTS_RESET   = 6'd32;
    localparam logic [STEP_W-1:0]     ANGLE_STEP_RESET = 15'd2048;

    // Pi/2 in Q2.30, the argument scale of the table series.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [TRIG_W-1:0] sine_rom_t [0:SINE_N];

    // Triangle indexes and run flags that travel with a vertex.
    typedef struct packed {
        logic               tri_valid;
        logic [BASE_W-1:0]  tri_first;
        logic [INDEX_W-1:0] tri_second;
        logic [INDEX_W-1:0] tri_third;
        logic               last;
    } tri_meta_t;

    // One coordinate handed from the sequencer to the trig unit.
    typedef struct packed {
        logic                      valid;
        logic                      coord_y;
        logic                      center_pt;
        logic [PHASE_BITS-1:0]     phase;
        logic [RADIUS_W-1:0]       radius;
        logic signed [COORD_W-1:0] center;
        tri_meta_t                 meta;
    } coord_req_t;

    // One finished coordinate leaving the trig unit.
    typedef struct packed {
        logic                      valid;
        logic                      coord_y;
        logic signed [COORD_W-1:0] value;
        tri_meta_t                 meta;
    } coord_res_t;

    // One step of the Taylor series: term times x squared, back in Q2.30.
    function automatic logic [63:0] taylor_next(input logic [63:0] t, input logic [63:0] x2);
        return (t * x2) >> 30;
    endfunction

    // Quarter-wave sine table in Q1.14, evaluated at elaboration.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= SINE_N; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i) + 64'(SINE_N / 2)) >> SINE_INDEX_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = taylor_next(term, x2) / 64'd6;   sum = sum - term;
            term = taylor_next(term, x2) / 64'd20;  sum = sum + term;
            term = taylor_next(term, x2) / 64'd42;  sum = sum - term;
            term = taylor_next(term, x2) / 64'd72;  sum = sum + term;
            term = taylor_next(term, x2) / 64'd110; sum = sum - term;
            term = taylor_next(term, x2) / 64'd156; sum = sum + term;
            term = taylor_next(term, x2) / 64'd210; sum = sum - term;
            term = taylor_next(term, x2) / 64'd272; sum = sum + term;
            term = taylor_next(term, x2) / 64'd342; sum = sum - term;
            term = taylor_next(term, x2) / 64'd420; sum = sum + term;
            term = taylor_next(term, x2) / 64'd506; sum = sum - term;
            term = taylor_next(term, x2) / 64'd600; sum = sum + term;
            rom[i] = TRIG_W'((sum + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Quadrant and table index bits of a phase; a short phase is zero filled.
    function automatic logic [TOP_W-1:0] phase_top(input logic [PHASE_BITS-1:0] phase);
        logic [PHASE_BITS+TOP_W-1:0] wide;
        wide = {phase, TOP_W'(0)};
        return wide[PHASE_BITS+TOP_W-1 -: TOP_W];
    endfunction

endpackage

FILE: hdl/cft_sequencer.sv
module cft_sequencer
    import cft_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]       radius_len,
    input  logic [BASE_W-1:0]         base_vertex,
    input  logic                      adv,
    output coord_req_t                req
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [SEGS_CFG_W-1:0]     segments_reg;
    logic [STEP_W-1:0]         angle_step_reg;
    logic [SEG_W-1:0]          segs_reg;
    logic [SEG_W-1:0]          k_reg;
    logic [SEG_W-1:0]          k_next;
    logic                      coord_y_reg;
    logic                      coord_y_next;
    logic [PHASE_BITS-1:0]     phase_reg;
    logic [PHASE_BITS-1:0]     phase_next;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic [BASE_W-1:0]         base_reg;
    logic [SEG_W-1:0]          segs_clamped;
    logic [SEG_W-1:0]          wrap_k;
    logic                      accept;
    logic                      issue;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_RUN) && adv;

    // Segment count held to its legal range.
    always_comb
    begin
        priority if (segments_reg < SEGS_CFG_W'(MIN_SEGMENTS))
            segs_clamped = SEG_W'(MIN_SEGMENTS);
        else if (segments_reg > SEGS_CFG_W'(MAX_SEGMENTS))
            segs_clamped = SEG_W'(MAX_SEGMENTS);
        else
            segs_clamped = SEG_W'(segments_reg);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg   <= SEGMENTS_RESET;
            angle_step_reg <= ANGLE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEGMENTS:   segments_reg   <= cfg_data[SEGS_CFG_W-1:0];
                REG_ANGLE_STEP: angle_step_reg <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Vertex counter: x then y for each vertex, phase advances per rim vertex.
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        coord_y_next = coord_y_reg;
        phase_next   = phase_reg;
        if (accept)
        begin
            state_next   = ST_RUN;
            k_next       = '0;
            coord_y_next = 1'b0;
            phase_next   = '0;
        end
        else if (issue)
        begin
            if (!coord_y_reg)
                coord_y_next = 1'b1;
            else
            begin
                coord_y_next = 1'b0;
                if (k_reg == segs_reg)
                    state_next = ST_IDLE;
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg != '0)
                        phase_next = phase_reg + PHASE_BITS'(angle_step_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            coord_y_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            coord_y_reg <= coord_y_next;
            phase_reg   <= phase_next;
        end
    end

    // Circle parameters captured with the transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            radius_reg <= radius_len;
            base_reg   <= base_vertex;
            segs_reg   <= segs_clamped;
        end
    end

    // Request for the current coordinate, with its fan triangle.
    assign wrap_k = (k_reg == segs_reg) ? '0 : k_reg;

    always_comb
    begin
        req.valid     = (state_reg == ST_RUN);
        req.coord_y   = coord_y_reg;
        req.center_pt = (k_reg == '0);
        req.phase     = phase_reg;
        req.radius    = radius_reg;
        req.center    = coord_y_reg ? cy_reg : cx_reg;
        if (k_reg == '0)
            req.meta = '0;
        else
        begin
            req.meta.tri_valid  = 1'b1;
            req.meta.tri_first  = base_reg;
            req.meta.tri_second = INDEX_W'(base_reg) + INDEX_W'(k_reg);
            req.meta.tri_third  = INDEX_W'(base_reg) + INDEX_W'(wrap_k) + INDEX_W'(1);
            req.meta.last       = (k_reg == segs_reg);
        end
    end

endmodule

FILE: hdl/cft_trig_unit.sv
module cft_trig_unit
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  coord_req_t req,
    output coord_res_t res
);

    logic [TOP_W-1:0]           top;
    logic [1:0]                 quad;
    logic [SINE_INDEX_BITS-1:0] j;
    logic [ROM_ADDR_W-1:0]      addr;

    logic                       s1_valid_reg;
    logic [TRIG_W-1:0]          s1_trig_reg;
    logic                       s1_neg_reg;
    logic                       s1_zero_reg;
    logic                       s1_coord_y_reg;
    logic [RADIUS_W-1:0]        s1_radius_reg;
    logic signed [COORD_W-1:0]  s1_center_reg;
    tri_meta_t                  s1_meta_reg;

    logic                       s2_valid_reg;
    logic [PROD_W-1:0]          s2_prod_reg;
    logic [PROD_W-1:0]          s2_prod_next;
    logic                       s2_neg_reg;
    logic                       s2_coord_y_reg;
    logic signed [COORD_W-1:0]  s2_center_reg;
    tri_meta_t                  s2_meta_reg;

    logic [PROD_W-1:0]          rnd;
    logic signed [SUM_W-1:0]    off;
    logic signed [SUM_W-1:0]    sum;

    // Fold the phase into a quadrant and a table address; cosine is one
    // quadrant ahead of sine.
    always_comb
    begin
        top  = phase_top(req.phase);
        quad = top[TOP_W-1 -: 2] + (req.coord_y ? 2'd0 : 2'd1);
        j    = top[SINE_INDEX_BITS-1:0];
        if (quad[0])
            addr = ROM_ADDR_W'(SINE_N) - {1'b0, j};
        else
            addr = {1'b0, j};
    end

    // Valid bits of the two stages move together under the advance enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: registered table read.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_trig_reg    <= SINE_ROM[addr];
            s1_neg_reg     <= quad[1];
            s1_zero_reg    <= req.center_pt;
            s1_coord_y_reg <= req.coord_y;
            s1_radius_reg  <= req.radius;
            s1_center_reg  <= req.center;
            s1_meta_reg    <= req.meta;
        end
    end

    // Stage two: radius times trig magnitude; the center vertex gets no offset.
    assign s2_prod_next = s1_zero_reg ? '0 : PROD_W'(s1_radius_reg) * PROD_W'(s1_trig_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg    <= s2_prod_next;
            s2_neg_reg     <= s1_neg_reg;
            s2_coord_y_reg <= s1_coord_y_reg;
            s2_center_reg  <= s1_center_reg;
            s2_meta_reg    <= s1_meta_reg;
        end
    end

    // Round the magnitude half away from zero, restore the sign, add and
    // saturate.
    always_comb
    begin
        rnd = s2_prod_reg + PROD_W'(ROUND_HALF);
        off = SUM_W'(rnd[PROD_W-1:FRAC_BITS]);
        if (s2_neg_reg)
            sum = SUM_W'(s2_center_reg) - off;
        else
            sum = SUM_W'(s2_center_reg) + off;
        res.valid   = s2_valid_reg;
        res.coord_y = s2_coord_y_reg;
        res.meta    = s2_meta_reg;
        priority if (sum > COORD_MAX)
            res.value = COORD_MAX[COORD_W-1:0];
        else if (sum < COORD_MIN)
            res.value = COORD_MIN[COORD_W-1:0];
        else
            res.value = sum[COORD_W-1:0];
    end

endmodule

FILE: hdl/circle_fan_tessellator.sv
// Each circle gives segments+1 results; the shared table port and multiplier produce one
// coordinate (x, then y) per cycle while the output register is free or being read. The first
// result passes the table read, product and output registers; a circle keeps the input closed
// until its last coordinate is issued. A full output register freezes the coordinate pipeline
// until it is taken. rst_n is asynchronous, active low: control state clears, the registers
// return to segments 32 and angle_step 2048; the sine table is constant.
module circle_fan_tessellator
    import cft_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]       radius_len,
    input  logic [BASE_W-1:0]         base_vertex,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] pos_x,
    output logic signed [COORD_W-1:0] pos_y,
    output logic                      tri_valid,
    output logic [BASE_W-1:0]         tri_first,
    output logic [INDEX_W-1:0]        tri_second,
    output logic [INDEX_W-1:0]        tri_third,
    output logic                      last_of_circle
);

    coord_req_t                req;
    coord_res_t                res;
    logic                      adv;
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] hold_x_reg;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    tri_meta_t                 meta_reg;

    // The pipeline moves whenever the output register is free or being read.
    assign adv = !out_valid_reg || out_ready;

    cft_sequencer u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius_len  (radius_len),
        .base_vertex (base_vertex),
        .adv         (adv),
        .req         (req)
    );

    cft_trig_unit u_trig
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (req),
        .res   (res)
    );

    // Output register fills when the y coordinate of a vertex comes out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= res.valid && res.coord_y;
    end

    // The x coordinate waits in a holding register for its y partner.
    always_ff @(posedge clk)
    begin
        if (adv && res.valid)
        begin
            if (res.coord_y)
            begin
                pos_x_reg <= hold_x_reg;
                pos_y_reg <= res.value;
                meta_reg  <= res.meta;
            end
            else
                hold_x_reg <= res.value;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;
    assign tri_valid      = meta_reg.tri_valid;
    assign tri_first      = meta_reg.tri_first;
    assign tri_second     = meta_reg.tri_second;
    assign tri_third      = meta_reg.tri_third;
    assign last_of_circle = meta_reg.last;

`ifndef SYNTH
    // A circle keeps the input closed for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after a circle was taken");

    // The run only ends on a rim vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_circle |-> tri_valid)
        else $error("run ended on a center vertex");

    // Rim vertices always lie after the center in the vertex list.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tri_valid |-> (tri_second > INDEX_W'(tri_first))
                                && (tri_third > INDEX_W'(tri_first)))
        else $error("fan triangle index at or before its center");
`endif

endmodule

FILE: sim/fan_vertex_check.sv
// Watches the configuration port and both channels of the circle fan tessellator,
// predicts the vertex run of every accepted circle and compares each output
// transaction with the oldest predicted vertex.
module fan_vertex_check
    import cft_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]       radius_len,
    input  logic [BASE_W-1:0]         base_vertex,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic                      tri_valid,
    input  logic [BASE_W-1:0]         tri_first,
    input  logic [INDEX_W-1:0]        tri_second,
    input  logic [INDEX_W-1:0]        tri_third,
    input  logic                      last_of_circle,
    output int                        fail_count,
    output int                        pending
);

    // One predicted vertex with its fan triangle.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      has_tri;
        logic [BASE_W-1:0]         first;
        logic [INDEX_W-1:0]        second;
        logic [INDEX_W-1:0]        third;
        logic                      last;
    } fan_vertex_t;

    fan_vertex_t             fan_vertex_q[$];
    logic [SEGS_CFG_W-1:0]   seg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [TRIG_W-1:0]       quarter_sine [0:SINE_N];

    // Quarter-wave sine entry in Q1.14 from a fixed-point Taylor series in Q2.30.
    function automatic logic [TRIG_W-1:0] sine_entry(input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(i) + 64'(SINE_N / 2)) >> SINE_INDEX_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return TRIG_W'((sum + 64'd32768) >> 16);
    endfunction

    // Signed Q1.14 sine or cosine of a phase, folded from the quarter wave.
    function automatic int trig_value(input logic [PHASE_BITS-1:0] phase, input bit want_cos);
        logic [TOP_W-1:0]           top;
        logic [1:0]                 quad;
        logic [SINE_INDEX_BITS-1:0] j;
        int                         mag;
        top  = phase[PHASE_BITS-1 -: TOP_W];
        quad = top[TOP_W-1 -: 2] + (want_cos ? 2'd1 : 2'd0);
        j    = top[SINE_INDEX_BITS-1:0];
        mag  = quad[0] ? int'(quarter_sine[SINE_N - int'(j)]) : int'(quarter_sine[j]);
        return quad[1] ? -mag : mag;
    endfunction

    // Center plus rounded radius times trig value, saturated to a coordinate.
    function automatic int rim_coord(input int center, input int radius, input int t);
        int mag;
        int off;
        int s;
        mag = radius * (t < 0 ? -t : t);
        off = (mag + ROUND_HALF) >>> FRAC_BITS;
        s   = (t < 0) ? center - off : center + off;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s;
    endfunction

    // Queue the center vertex and every rim vertex of one circle.
    task automatic predict_fan(input logic signed [COORD_W-1:0] cx,
                               input logic signed [COORD_W-1:0] cy,
                               input logic [RADIUS_W-1:0] r,
                               input logic [BASE_W-1:0] base);
        fan_vertex_t           v;
        int                    segs;
        logic [PHASE_BITS-1:0] phase;
        segs = int'(seg_reg);
        if (segs < MIN_SEGMENTS)
            segs = MIN_SEGMENTS;
        if (segs > MAX_SEGMENTS)
            segs = MAX_SEGMENTS;
        v = '0;
        v.x = cx;
        v.y = cy;
        fan_vertex_q.push_back(v);
        for (int k = 1; k <= segs; k++)
        begin
            phase    = PHASE_BITS'((k - 1) * int'(step_reg));
            v.x      = COORD_W'(rim_coord(int'(cx), int'(r), trig_value(phase, 1'b1)));
            v.y      = COORD_W'(rim_coord(int'(cy), int'(r), trig_value(phase, 1'b0)));
            v.has_tri = 1'b1;
            v.first  = base;
            v.second = INDEX_W'(int'(base) + k);
            v.third  = INDEX_W'(int'(base) + (k % segs) + 1);
            v.last   = (k == segs);
            fan_vertex_q.push_back(v);
        end
    endtask

    // Report one field that differs from its prediction.
    function automatic int field_differs(input string name, input integer want_v,
                                         input integer got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i <= SINE_N; i++)
            quarter_sine[i] = sine_entry(i);
    end

    // Track register writes, predict on input transactions, check output transactions.
    always @(posedge clk or negedge rst_n)
    begin
        fan_vertex_t want;
        if (!rst_n)
        begin
            seg_reg  = SEGMENTS_RESET;
            step_reg = ANGLE_STEP_RESET;
            fan_vertex_q.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SEGMENTS)
                    seg_reg = cfg_data[SEGS_CFG_W-1:0];
                else if (cfg_index == REG_ANGLE_STEP)
                    step_reg = cfg_data[STEP_W-1:0];
            end
            if (in_valid && in_ready)
                predict_fan(center_x, center_y, radius_len, base_vertex);
            if (out_valid && out_ready)
            begin
                if (fan_vertex_q.size() == 0)
                begin
                    $error("output transaction with no predicted vertex waiting");
                    fail_count++;
                end
                else
                begin
                    want = fan_vertex_q.pop_front();
                    fail_count += field_differs("pos_x", want.x, pos_x);
                    fail_count += field_differs("pos_y", want.y, pos_y);
                    fail_count += field_differs("tri_valid", want.has_tri, tri_valid);
                    fail_count += field_differs("tri_first", want.first, tri_first);
                    fail_count += field_differs("tri_second", want.second, tri_second);
                    fail_count += field_differs("tri_third", want.third, tri_third);
                    fail_count += field_differs("last_of_circle", want.last, last_of_circle);
                end
            end
            pending = fan_vertex_q.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Stimulus for the circle fan tessellator: directed circles at the field
// extremes and register corners, then random circles under several settings.
module tb;
    import cft_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       radius_len;
    logic [BASE_W-1:0]         base_vertex;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      tri_valid;
    logic [BASE_W-1:0]         tri_first;
    logic [INDEX_W-1:0]        tri_second;
    logic [INDEX_W-1:0]        tri_third;
    logic                      last_of_circle;
    int                        fail_count;
    int                        pending;
    int                        cycle_count;
    bit                        steady;

    circle_fan_tessellator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius_len     (radius_len),
        .base_vertex    (base_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .tri_valid      (tri_valid),
        .tri_first      (tri_first),
        .tri_second     (tri_second),
        .tri_third      (tri_third),
        .last_of_circle (last_of_circle)
    );

    fan_vertex_check u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius_len     (radius_len),
        .base_vertex    (base_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .tri_valid      (tri_valid),
        .tri_first      (tri_first),
        .tri_second     (tri_second),
        .tri_third      (tri_third),
        .last_of_circle (last_of_circle),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Give up on a hung run.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls now and then, except during the steady stretch.
    always @(negedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 6);
    end

    // Present one circle, with a random gap ahead of it, and wait for its transaction.
    task automatic send_circle(input logic signed [COORD_W-1:0] cx,
                               input logic signed [COORD_W-1:0] cy,
                               input logic [RADIUS_W-1:0] r,
                               input logic [BASE_W-1:0] base);
        while (!steady && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        center_x    <= cx;
        center_y    <= cy;
        radius_len  <= r;
        base_vertex <= base;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Let every predicted vertex come out, then let the tail settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_fan(input int segs, input int step);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEGMENTS;
        cfg_data  <= CFG_DATA_W'(segs);
        @(negedge clk);
        cfg_index <= REG_ANGLE_STEP;
        cfg_data  <= CFG_DATA_W'(step);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random circle: full range, unsaturated, or near the coordinate and index limits.
    task automatic send_random_circle();
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       r;
        logic [BASE_W-1:0]         base;
        case ($urandom_range(2))
            0:
            begin
                cx   = COORD_W'($urandom);
                cy   = COORD_W'($urandom);
                r    = RADIUS_W'($urandom);
                base = BASE_W'($urandom);
            end
            1:
            begin
                cx   = COORD_W'(int'($urandom_range(16383)) - 8192);
                cy   = COORD_W'(int'($urandom_range(16383)) - 8192);
                r    = RADIUS_W'($urandom_range(16384));
                base = BASE_W'($urandom);
            end
            default:
            begin
                cx   = $urandom_range(1) ? COORD_W'(32767 - int'($urandom_range(2000)))
                                         : COORD_W'(-32768 + int'($urandom_range(2000)));
                cy   = $urandom_range(1) ? COORD_W'(32767 - int'($urandom_range(2000)))
                                         : COORD_W'(-32768 + int'($urandom_range(2000)));
                r    = RADIUS_W'($urandom_range(32767));
                base = BASE_W'(1048575 - int'($urandom_range(63)));
            end
        endcase
        send_circle(cx, cy, r, base);
    endtask

    initial
    begin
        int segs;
        int eff;
        int step;
        steady      = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SEGMENTS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        center_x    = '0;
        center_y    = '0;
        radius_len  = '0;
        base_vertex = '0;
        out_ready   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero circle, both saturation directions, unit circle.
        send_circle(16'sd0, 16'sd0, 15'd0, 20'd0);
        send_circle(16'sd32767, 16'sd32767, 15'd32767, 20'd1048575);
        send_circle(-16'sd32768, -16'sd32768, 15'd32767, 20'd1048544);
        send_circle(16'sd0, 16'sd0, 15'd16384, 20'd1000);
        send_circle(-16'sd32768, 16'sd32767, 15'd0, 20'd5);
        send_circle(16'sd12345, -16'sd4321, 15'd21845, 20'h55555);

        // Largest fan.
        set_fan(MAX_SEGMENTS, 1040);
        send_circle(16'sd0, 16'sd0, 15'd16384, 20'd1048575);
        send_circle(16'sd30000, -16'sd30000, 15'd20000, 20'hAAAAA);

        // Smallest fan with the largest intended step.
        set_fan(MIN_SEGMENTS, 21845);
        send_circle(16'sd100, 16'sd200, 15'd16384, 20'd1048575);
        send_circle(-16'sd1, -16'sd1, 15'd1, 20'd7);

        // Segment counts below the range act as three; zero step keeps phase 0.
        set_fan(0, 0);
        send_circle(16'sd0, 16'sd0, 15'd16384, 20'd0);
        send_circle(16'sd32767, -16'sd32768, 15'd32767, 20'd1048575);
        set_fan(1, 32767);
        send_circle(-16'sd8192, 16'sd8192, 15'd8192, 20'd42);
        send_circle(16'sd1, 16'sd1, 15'd32767, 20'd1048574);
        set_fan(2, 1);
        send_circle(16'sd0, 16'sd0, 15'd32767, 20'd99);
        set_fan(63, 32767);
        send_circle(16'sd0, 16'sd0, 15'd16384, 20'd1048575);

        // Random circles under a handful of random settings; one stretch never stalls.
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(9))
                0: segs = $urandom_range(2);
                1: segs = MAX_SEGMENTS;
                default: segs = $urandom_range(MIN_SEGMENTS, 16);
            endcase
            eff = (segs < MIN_SEGMENTS) ? MIN_SEGMENTS : segs;
            if ($urandom_range(9) < 7)
                step = 65536 / eff;
            else
                step = $urandom_range(32767);
            set_fan(segs, step);
            steady = (phase == 2);
            for (int i = 0; i < 25; i++)
                send_random_circle();
        end
        steady = 1'b0;

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cft_pkg.sv
hdl/cft_sequencer.sv
hdl/cft_trig_unit.sv
hdl/circle_fan_tessellator.sv
sim/fan_vertex_check.sv
sim/tb.sv
